### design/sga_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the softened gravity accumulator.
// Used by sga_unit and softened_gravity_accumulate; no dependencies.
package sga_pkg;

  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int G_W       = 32;
  localparam int MASS_W    = 32;
  localparam int GM_W      = G_W + MASS_W;
  localparam int SOFT_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOFTENING = 2'd1;

  localparam logic [G_W-1:0] GRAVITY_RESET = 32'h0100_0000;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } sga_op_e;

  // request to the shared unit: start pulse, operation, step count
  typedef struct packed {
    logic             start;
    sga_op_e          op;
    logic [CNT_W-1:0] cnt;
  } sga_req_t;

endpackage

### design/sga_unit.sv
`timescale 1ns / 1ps
// Shared serial arithmetic unit: shift-add multiply, restoring divide and
// restoring square root over one W-bit adder. Depends on sga_pkg.
module sga_unit #(
  parameter int W = 113
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sga_pkg::sga_req_t req_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  input  logic [W-1:0]     c_i,
  output logic             done_o,
  output logic [W-1:0]     x_o,
  output logic [W-1:0]     y_o,
  output logic [W-1:0]     z_o
);
  import sga_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  sga_op_e          op_q, op_d;
  logic [W-1:0]     x_q, x_d, y_q, y_d, z_q, z_d;

  logic [W-1:0] opa, opb;
  logic         sub;
  logic [W:0]   sum;
  logic         ge;

  // MUL: z += x when y[0]; DIV/SQRT: trial subtract of the shifted remainder
  always_comb begin
    opa = z_q;
    opb = '0;
    sub = 1'b0;
    case (op_q)
      OP_MUL: begin
        opa = z_q;
        opb = y_q[0] ? x_q : '0;
        sub = 1'b0;
      end
      OP_DIV: begin
        opa = {z_q[W-2:0], y_q[W-1]};
        opb = x_q;
        sub = 1'b1;
      end
      OP_SQRT: begin
        opa = {z_q[W-3:0], y_q[W-1:W-2]};
        opb = {x_q[W-3:0], 2'b01};
        sub = 1'b1;
      end
      default: begin
        opa = z_q;
        opb = '0;
        sub = 1'b0;
      end
    endcase
    sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + (W+1)'(sub);
    ge  = sum[W];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.cnt;
      op_d   = req_i.op;
      x_d    = a_i;
      y_d    = b_i;
      z_d    = c_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      case (op_q)
        OP_MUL: begin
          z_d = sum[W-1:0];
          x_d = {x_q[W-2:0], 1'b0};
          y_d = {1'b0, y_q[W-1:1]};
        end
        OP_DIV: begin
          z_d = ge ? sum[W-1:0] : opa;
          y_d = {y_q[W-2:0], ge};
        end
        OP_SQRT: begin
          z_d = ge ? sum[W-1:0] : opa;
          x_d = {x_q[W-2:0], ge};
          y_d = {y_q[W-3:0], 2'b00};
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

### design/softened_gravity_accumulate.sv
`timescale 1ns / 1ps
// Softened gravity accumulator top level: input capture, sequencer, running
// sums and output register. Depends on sga_pkg and sga_unit.
//
// Usage: an item (target/source positions and masses) enters on s_axis; tuser
// is the mode (1 = pairwise, also give the source reaction), tlast ends a run.
// One result item per input leaves on m_axis: the running acceleration sum,
// the reaction terms (zero in one-sided mode), tlast = copy of the input
// tlast, tuser = overflow (a term or a sum saturated, or zero distance).
// Registers (gravity constant, softening) are written on the cfg channel,
// which is always ready; write them only while the block is idle.
// Timing: one item at a time through one serial unit that takes one bit (two
// for the square root) per cycle. An item squares and sums the distances,
// takes the root, adds the softening, cubes it and forms G times each mass
// needed; each term then divides, saturates early, or stays zero for a zero
// axis distance. s_axis_tready is high only between items.
// The result sits in an output register; while the receiver stalls, the
// sequencer holds at its end and takes no new item.
// Reset clears the running sums and loads the gravity constant to 1.0 and
// the softening to zero.
module softened_gravity_accumulate #(
  parameter int COORD_WIDTH = 32,
  parameter int ACCEL_WIDTH = 48
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // target_x, target_y, target_z, source_x, source_y, source_z,
  // target_mass, source_mass (low bits first)
  input  logic [((6*COORD_WIDTH+64+7)/8)*8-1:0]        s_axis_tdata,
  input  logic                                         s_axis_tuser, // mode
  input  logic                                         s_axis_tlast, // last
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // accel_x, accel_y, accel_z, reaction_x, reaction_y, reaction_z
  output logic [((6*ACCEL_WIDTH+7)/8)*8-1:0]           m_axis_tdata,
  output logic                                         m_axis_tuser, // overflow
  output logic                                         m_axis_tlast, // run_end
  input  logic                                         cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  logic [sga_pkg::CFG_IDX_W-1:0]                cfg_index_i,
  input  logic [31:0]                                  cfg_data_i
);
  import sga_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int AW    = ACCEL_WIDTH;
  localparam int MW    = CW + 1;
  localparam int SW    = 2 * MW;
  localparam int RW    = ((MW > SOFT_W) ? MW : SOFT_W) + 1;
  localparam int DW    = 3 * RW;
  localparam int NNW   = GM_W + MW;
  localparam int W0    = (NNW + 16 > DW + 1) ? NNW + 16 : DW + 1;
  localparam int W     = (W0 > SW + 2) ? W0 : SW + 2;
  localparam int HW    = NNW - (AW - 16);
  localparam int OUT_W = ((6*AW+7)/8)*8;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_SQ   = 11'b00000000010,
    S_ROOT = 11'b00000000100,
    S_RCHK = 11'b00000001000,
    S_R2   = 11'b00000010000,
    S_R3   = 11'b00000100000,
    S_GM   = 11'b00001000000,
    S_NUM  = 11'b00010000000,
    S_CHK  = 11'b00100000000,
    S_DIV  = 11'b01000000000,
    S_DONE = 11'b10000000000
  } sga_state_e;

  sga_state_e state_q, state_d;
  logic       go_q, go_d;
  logic [1:0] k_q, k_d;
  logic       side_q, side_d;

  logic [G_W-1:0]    gravity_q;
  logic [SOFT_W-1:0] soft_q;

  logic                 mode_q, mode_d, last_q, last_d, ovf_q, ovf_d;
  logic [MASS_W-1:0]    mt_q, mt_d, ms_q, ms_d;
  logic [MW-1:0]        dmag_q [3];
  logic [MW-1:0]        dmag_d [3];
  logic                 dneg_q [3];
  logic                 dneg_d [3];
  logic [SW-1:0]        s_q, s_d;
  logic [RW-1:0]        r_q, r_d;
  logic [DW-1:0]        den_q, den_d;
  logic [GM_W-1:0]      gms_q, gms_d, gmt_q, gmt_d;
  logic [NNW-1:0]       n_q, n_d;
  logic signed [AW-1:0] term_q [3];
  logic signed [AW-1:0] term_d [3];
  logic signed [AW-1:0] react_q [3];
  logic signed [AW-1:0] react_d [3];
  logic signed [AW-1:0] acc_q [3];
  logic signed [AW-1:0] acc_d [3];

  logic              out_valid_q, out_valid_d;
  logic [OUT_W-1:0]  out_data_q, out_data_d;
  logic              out_last_q, out_last_d, out_ovf_q, out_ovf_d;

  sga_req_t     req;
  logic [W-1:0] ua, ub, uc, ux, uy, uz;
  logic         udone;

  logic [HW-1:0]   high;
  logic [AW-1:0]   q_in, lim, q_cl;
  logic            neg, last_term;
  logic [CW:0]     dsig [3];
  logic [AW:0]     ssum [3];
  logic            sum_ovf;

  sga_unit #(.W(W)) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (ua),
    .b_i    (ub),
    .c_i    (uc),
    .done_o (udone),
    .x_o    (ux),
    .y_o    (uy),
    .z_o    (uz)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= GRAVITY_RESET;
      soft_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GRAVITY:   gravity_q <= cfg_data_i;
        REG_SOFTENING: soft_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsig[i] = {s_axis_tdata[(i+3)*CW + CW-1], s_axis_tdata[(i+3)*CW +: CW]}
              - {s_axis_tdata[i*CW + CW-1], s_axis_tdata[i*CW +: CW]};
    end
  end

  assign high      = n_q[NNW-1:AW-16];
  assign neg       = dneg_q[k_q] ^ side_q;
  assign lim       = {1'b0, {(AW-1){1'b1}}} + AW'(neg);
  assign q_in      = (state_q == S_DIV) ? uy[AW-1:0] : '1;
  assign q_cl      = (q_in > lim) ? lim : q_in;
  assign last_term = (k_q == 2'd2) && (side_q || !mode_q);

  always_comb begin
    sum_ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ssum[i]  = {acc_q[i][AW-1], acc_q[i]} + {term_q[i][AW-1], term_q[i]};
      acc_d[i] = ssum[i][AW-1:0];
      if (ssum[i][AW] != ssum[i][AW-1]) begin
        sum_ovf  = 1'b1;
        acc_d[i] = ssum[i][AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    go_d        = go_q;
    k_d         = k_q;
    side_d      = side_q;
    mode_d      = mode_q;
    last_d      = last_q;
    ovf_d       = ovf_q;
    mt_d        = mt_q;
    ms_d        = ms_q;
    dmag_d      = dmag_q;
    dneg_d      = dneg_q;
    s_d         = s_q;
    r_d         = r_q;
    den_d       = den_q;
    gms_d       = gms_q;
    gmt_d       = gmt_q;
    n_d         = n_q;
    term_d      = term_q;
    react_d     = react_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    req.start   = 1'b0;
    req.op      = OP_MUL;
    req.cnt     = '0;
    ua          = '0;
    ub          = '0;
    uc          = '0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d = s_axis_tuser;
          last_d = s_axis_tlast;
          ovf_d  = 1'b0;
          mt_d   = s_axis_tdata[6*CW +: MASS_W];
          ms_d   = s_axis_tdata[6*CW+MASS_W +: MASS_W];
          for (int i = 0; i < 3; i++) begin
            dneg_d[i]  = dsig[i][CW];
            dmag_d[i]  = dsig[i][CW] ? MW'(-dsig[i]) : MW'(dsig[i]);
            term_d[i]  = '0;
            react_d[i] = '0;
          end
          k_d     = 2'd0;
          go_d    = 1'b0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        req.start = !go_q;
        req.op    = OP_MUL;
        req.cnt   = CNT_W'(MW);
        ua        = W'(dmag_q[k_q]);
        ub        = W'(dmag_q[k_q]);
        uc        = (k_q == 2'd0) ? '0 : uz;
        go_d      = 1'b1;
        if (udone) begin
          go_d = 1'b0;
          if (k_q == 2'd2) begin
            s_d     = uz[SW-1:0];
            state_d = S_ROOT;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      S_ROOT: begin
        req.start = !go_q;
        req.op    = OP_SQRT;
        req.cnt   = CNT_W'(SW/2);
        ub        = W'(s_q) << (W - SW);
        go_d      = 1'b1;
        if (udone) begin
          go_d    = 1'b0;
          r_d     = RW'(ux[MW-1:0]) + RW'(soft_q);
          state_d = S_RCHK;
        end
      end
      S_RCHK: begin
        if (r_q == '0) begin
          ovf_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_R2;
        end
      end
      S_R2: begin
        req.start = !go_q;
        req.op    = OP_MUL;
        req.cnt   = CNT_W'(RW);
        ua        = W'(r_q);
        ub        = W'(r_q);
        go_d      = 1'b1;
        if (udone) begin
          go_d    = 1'b0;
          state_d = S_R3;
        end
      end
      S_R3: begin
        req.start = !go_q;
        req.op    = OP_MUL;
        req.cnt   = CNT_W'(RW);
        ua        = uz;
        ub        = W'(r_q);
        go_d      = 1'b1;
        if (udone) begin
          go_d    = 1'b0;
          den_d   = uz[DW-1:0];
          side_d  = 1'b0;
          state_d = S_GM;
        end
      end
      S_GM: begin
        req.start = !go_q;
        req.op    = OP_MUL;
        req.cnt   = CNT_W'(MASS_W);
        ua        = W'(gravity_q);
        ub        = W'(side_q ? mt_q : ms_q);
        go_d      = 1'b1;
        if (udone) begin
          go_d = 1'b0;
          if (side_q) gmt_d = uz[GM_W-1:0];
          else        gms_d = uz[GM_W-1:0];
          if (!side_q && mode_q) begin
            side_d = 1'b1;
          end else begin
            side_d  = 1'b0;
            k_d     = 2'd0;
            state_d = S_NUM;
          end
        end
      end
      S_NUM: begin
        if (dmag_q[k_q] == '0) begin
          // zero axis distance: term stays zero
          if (last_term) begin
            state_d = S_DONE;
          end else if (!side_q && mode_q) begin
            side_d = 1'b1;
          end else begin
            side_d = 1'b0;
            k_d    = k_q + 2'd1;
          end
        end else begin
          req.start = !go_q;
          req.op    = OP_MUL;
          req.cnt   = CNT_W'(MW);
          ua        = W'(side_q ? gmt_q : gms_q);
          ub        = W'(dmag_q[k_q]);
          go_d      = 1'b1;
          if (udone) begin
            go_d    = 1'b0;
            n_d     = uz[NNW-1:0];
            state_d = S_CHK;
          end
        end
      end
      S_CHK: begin
        // quotient would need more than AW bits: saturate without dividing
        if (W'(high) >= W'(den_q)) state_d = S_DIV;
        else                       state_d = S_DIV;
        if (W'(high) >= W'(den_q)) begin
          ovf_d = 1'b1;
          if (side_q) react_d[k_q] = neg ? AW'(-q_cl) : q_cl;
          else        term_d[k_q]  = neg ? AW'(-q_cl) : q_cl;
          if (last_term) begin
            state_d = S_DONE;
          end else if (!side_q && mode_q) begin
            side_d  = 1'b1;
            state_d = S_NUM;
          end else begin
            side_d  = 1'b0;
            k_d     = k_q + 2'd1;
            state_d = S_NUM;
          end
        end
      end
      S_DIV: begin
        req.start = !go_q;
        req.op    = OP_DIV;
        req.cnt   = CNT_W'(AW);
        ua        = W'(den_q);
        ub        = W'({n_q[AW-17:0], 16'b0}) << (W - AW);
        uc        = W'(high);
        go_d      = 1'b1;
        if (udone) begin
          go_d = 1'b0;
          if (q_in > lim) ovf_d = 1'b1;
          if (side_q) react_d[k_q] = neg ? AW'(-q_cl) : q_cl;
          else        term_d[k_q]  = neg ? AW'(-q_cl) : q_cl;
          if (last_term) begin
            state_d = S_DONE;
          end else if (!side_q && mode_q) begin
            side_d  = 1'b1;
            state_d = S_NUM;
          end else begin
            side_d  = 1'b0;
            k_d     = k_q + 2'd1;
            state_d = S_NUM;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_last_d  = last_q;
          out_ovf_d   = ovf_q | sum_ovf;
          out_data_d  = '0;
          for (int i = 0; i < 3; i++) begin
            out_data_d[i*AW +: AW]     = acc_d[i];
            out_data_d[(i+3)*AW +: AW] = react_q[i];
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      k_q         <= '0;
      side_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) acc_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      go_q        <= go_d;
      k_q         <= k_d;
      side_q      <= side_d;
      out_valid_q <= out_valid_d;
      if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
        for (int i = 0; i < 3; i++) acc_q[i] <= last_q ? '0 : acc_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    last_q     <= last_d;
    ovf_q      <= ovf_d;
    mt_q       <= mt_d;
    ms_q       <= ms_d;
    dmag_q     <= dmag_d;
    dneg_q     <= dneg_d;
    s_q        <= s_d;
    r_q        <= r_d;
    den_q      <= den_d;
    gms_q      <= gms_d;
    gmt_q      <= gmt_d;
    n_q        <= n_d;
    term_q     <= term_d;
    react_q    <= react_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule
